[rtl/trd_pkg.sv]
package trd_pkg;

    // Storage geometry. DEPTH must stay a power of two: slot arithmetic wraps by truncation.
    localparam int DEPTH     = 256;
    localparam int TASK_BITS = 16;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // Request field widths.
    localparam int CMD_BITS    = 3;
    localparam int OFFSET_BITS = 8;
    localparam int STATUS_BITS = 2;

    // Command codes carried in a request.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_TAKE_AT    = 3'd2,
        CMD_REMOVE_ALL = 3'd3,
        CMD_PEEK       = 3'd4
    } trd_cmd_t;

    // Status codes returned with each result.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_OFFSET = 2'd2
    } trd_status_t;

    // One request.
    typedef struct packed {
        logic [CMD_BITS-1:0]    cmd;
        logic [TASK_BITS-1:0]   task_id;
        logic [OFFSET_BITS-1:0] offset;
    } trd_req_t;

    // One result.
    typedef struct packed {
        trd_status_t          status;
        logic [TASK_BITS-1:0] task_out;
        logic [CNT_BITS-1:0]  removed_count;
        logic [CNT_BITS-1:0]  occupancy;
    } trd_result_t;

endpackage

[rtl/task_ring_deque.sv]
// Ring-buffer task deque with a fixed depth of 256 task identifiers.
// A request (cmd, task_id, offset) is taken at a rising edge where start is
// high and busy is low. Busy stays high while the request is worked on, and
// exactly one result (status, task_out, removed_count, occupancy) follows,
// shown for a single cycle with done high. The receiver cannot stall the
// block: a result is gone after its cycle. A new request may be issued in
// the same cycle that done is high.
// All work goes through one single-port store and one slot adder
// (head plus offset), so each command's work is set by store accesses:
//   push_back, push_front, unknown command, bad offset: execute step only.
//   peek, take_at at offset 0: one read. take_at at another offset: also a
//   read of the head entry and a write of it into the vacated slot. remove_all:
//   a read and compare per scanned entry, a head-entry copy per match not at head.
// Reset (rst_n low, asynchronous) empties the queue and clears the sequencer;
// store contents are left as they are and only written slots are ever read.
module task_ring_deque (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  trd_pkg::trd_req_t    request,
    output logic                 busy,
    output logic                 done,
    output trd_pkg::trd_result_t result
);
    import trd_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_RD1  = 8'b0000_0100,
        S_RD2  = 8'b0000_1000,
        S_SCAN = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_COPY = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    trd_req_t              req_reg, req_next;
    logic [ADDR_BITS-1:0]  head_reg, head_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   idx_reg, idx_next;
    trd_status_t           status_reg, status_next;
    logic [TASK_BITS-1:0]  task_out_reg, task_out_next;
    logic [CNT_BITS-1:0]   removed_reg, removed_next;
    logic                  done_reg, done_next;

    // Store port and the shared slot adder.
    logic [TASK_BITS-1:0]  mem [DEPTH];
    logic [TASK_BITS-1:0]  rd_data_reg;
    logic [ADDR_BITS-1:0]  off_sel;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic                  mem_wr_en;
    logic                  mem_rd_en;
    logic [TASK_BITS-1:0]  mem_wr_data;
    logic                  finish;
    logic                  full;

    assign mem_addr = head_reg + off_sel;
    assign full     = (count_reg == CNT_BITS'(DEPTH));

    // Single-port store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // Sequencer: next state, store access and queue updates.
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        task_out_next = task_out_reg;
        removed_next  = removed_reg;
        done_next     = 1'b0;
        off_sel       = '0;
        mem_wr_en     = 1'b0;
        mem_rd_en     = 1'b0;
        mem_wr_data   = req_reg.task_id;
        finish        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next      = request;
                    status_next   = ST_OK;
                    task_out_next = '0;
                    removed_next  = '0;
                    idx_next      = '0;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (req_reg.cmd)
                    CMD_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            off_sel    = count_reg[ADDR_BITS-1:0];
                            mem_wr_en  = 1'b1;
                            count_next = count_reg + CNT_BITS'(1);
                        end
                        finish = 1'b1;
                    end
                    CMD_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            off_sel    = '1;
                            mem_wr_en  = 1'b1;
                            head_next  = mem_addr;
                            count_next = count_reg + CNT_BITS'(1);
                        end
                        finish = 1'b1;
                    end
                    CMD_TAKE_AT, CMD_PEEK:
                    begin
                        if (CNT_BITS'(req_reg.offset) >= count_reg)
                        begin
                            status_next = ST_BAD_OFFSET;
                            finish      = 1'b1;
                        end
                        else
                        begin
                            off_sel    = ADDR_BITS'(req_reg.offset);
                            mem_rd_en  = 1'b1;
                            state_next = S_RD1;
                        end
                    end
                    CMD_REMOVE_ALL:
                    begin
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            // Entry at the offset is back; a take at another offset also needs the head entry.
            S_RD1:
            begin
                task_out_next = rd_data_reg;
                if (req_reg.cmd == CMD_PEEK)
                begin
                    finish = 1'b1;
                end
                else if (req_reg.offset == '0)
                begin
                    head_next  = head_reg + ADDR_BITS'(1);
                    count_next = count_reg - CNT_BITS'(1);
                    finish     = 1'b1;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_RD2;
                end
            end

            // Move the head entry into the vacated slot.
            S_RD2:
            begin
                off_sel     = ADDR_BITS'(req_reg.offset);
                mem_wr_en   = 1'b1;
                mem_wr_data = rd_data_reg;
                head_next   = head_reg + ADDR_BITS'(1);
                count_next  = count_reg - CNT_BITS'(1);
                finish      = 1'b1;
            end

            // Walk the occupied range for remove_all.
            S_SCAN:
            begin
                if (idx_reg >= count_reg)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    off_sel    = idx_reg[ADDR_BITS-1:0];
                    mem_rd_en  = 1'b1;
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (rd_data_reg == req_reg.task_id)
                begin
                    if (idx_reg == '0)
                    begin
                        head_next    = head_reg + ADDR_BITS'(1);
                        count_next   = count_reg - CNT_BITS'(1);
                        removed_next = removed_reg + CNT_BITS'(1);
                        state_next   = S_SCAN;
                    end
                    else
                    begin
                        mem_rd_en  = 1'b1;
                        state_next = S_COPY;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_BITS'(1);
                    state_next = S_SCAN;
                end
            end

            S_COPY:
            begin
                off_sel      = idx_reg[ADDR_BITS-1:0];
                mem_wr_en    = 1'b1;
                mem_wr_data  = rd_data_reg;
                head_next    = head_reg + ADDR_BITS'(1);
                count_next   = count_reg - CNT_BITS'(1);
                removed_next = removed_reg + CNT_BITS'(1);
                state_next   = S_SCAN;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Every command ends by showing its result for one cycle.
        if (finish)
        begin
            state_next = S_IDLE;
            done_next  = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Request copy, scan index and result fields.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
        task_out_reg <= task_out_next;
        removed_reg  <= removed_next;
    end

    assign busy                 = (state_reg != S_IDLE);
    assign done                 = done_reg;
    assign result.status        = status_reg;
    assign result.task_out      = task_out_reg;
    assign result.removed_count = removed_reg;
    assign result.occupancy     = count_reg;

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count beyond depth");

    // A result strobe lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // An accepted request always enters the execute step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    // The store is only written while a request is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> busy)
        else $error("store written while idle");

    // Occupancy moves by at most one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CNT_BITS'(1))
        || (count_reg + CNT_BITS'(1) == $past(count_reg)))
        else $error("entry count jumped");

endmodule
